### rtl/rotated_rect_bounding_box_core_assert.svh
// assertion macros for the rotated rectangle bounding box core
// expects clk_i and rst_ni in the scope of each use
`ifndef ROTATED_RECT_BOUNDING_BOX_CORE_ASSERT_SVH
`define ROTATED_RECT_BOUNDING_BOX_CORE_ASSERT_SVH

// same-cycle implication
`define RRBB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication
`define RRBB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

### rtl/rrbb_pkg.sv
// shared constants for the rotated rectangle bounding box core
// no dependencies
`default_nettype none

package rrbb_pkg;

  // angle units are 1/64 degree
  localparam logic [14:0] FULL_TURN    = 15'd23040;
  localparam logic [14:0] HALF_TURN    = 15'd11520;
  localparam logic [12:0] QUARTER_TURN = 13'd5760;
  localparam int unsigned ANG_IDX_W    = 12;
  localparam logic [ANG_IDX_W-1:0] EIGHTH_TURN = 12'd2880;

  // field widths
  localparam int unsigned POS_W = 24;
  localparam int unsigned LEN_W = 23;
  localparam int unsigned ANG_W = 16;
  localparam int unsigned BOXP_W = 25;
  localparam int unsigned BOXL_W = 24;

  // packed word widths
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 104;

endpackage

`default_nettype wire

### rtl/rrbb_trig_rom.sv
// sine and cosine table over one octant, registered read
// depends on rrbb_pkg
`default_nettype none

module rrbb_trig_rom #(
  parameter int unsigned TRIG_FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [rrbb_pkg::ANG_IDX_W-1:0]    addr_i,
  output logic      [TRIG_FRAC_BITS:0]           sin_o,
  output logic      [TRIG_FRAC_BITS:0]           cos_o
);

  localparam int unsigned TW    = TRIG_FRAC_BITS + 1;
  localparam int unsigned DROP  = 32 - TRIG_FRAC_BITS;
  localparam int unsigned DEPTH = int'(rrbb_pkg::EIGHTH_TURN) + 1;
  localparam logic [127:0] PI_Q32  = 128'h3_243F_6A89;
  localparam logic [127:0] ONE_Q32 = 128'h1_0000_0000;
  localparam logic [127:0] HALF_T  = 128'(rrbb_pkg::HALF_TURN);
  localparam logic [127:0] RND     = 128'(1) << (DROP - 1);

  typedef logic [2*TW-1:0] rom_t [DEPTH];

  // q32 product
  function automatic logic [127:0] mulq(input logic [127:0] a, input logic [127:0] b);
    logic [127:0] m;
    m = (a * b) >> 32;
    return m;
  endfunction

  // horner evaluation of sin and cos per entry
  function automatic rom_t build_rom();
    rom_t r;
    logic [127:0] x, x2, t, s32, c32, sn, cs;
    for (int b = 0; b < DEPTH; b++) begin
      x  = (128'(b) * PI_Q32) / HALF_T;
      x2 = mulq(x, x);
      t  = ONE_Q32 - mulq(x2, ONE_Q32) / 110;
      t  = ONE_Q32 - mulq(x2, t) / 72;
      t  = ONE_Q32 - mulq(x2, t) / 42;
      t  = ONE_Q32 - mulq(x2, t) / 20;
      t  = ONE_Q32 - mulq(x2, t) / 6;
      s32 = mulq(x, t);
      t  = ONE_Q32 - mulq(x2, ONE_Q32) / 90;
      t  = ONE_Q32 - mulq(x2, t) / 56;
      t  = ONE_Q32 - mulq(x2, t) / 30;
      t  = ONE_Q32 - mulq(x2, t) / 12;
      c32 = ONE_Q32 - mulq(x2, t) / 2;
      sn = (s32 + RND) >> DROP;
      cs = (c32 + RND) >> DROP;
      r[b] = {sn[TW-1:0], cs[TW-1:0]};
    end
    return r;
  endfunction

  localparam rom_t TRIG_ROM = build_rom();

  logic [2*TW-1:0] rd_q;

  // registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q <= TRIG_ROM[addr_i];
    end
  end

  assign sin_o = rd_q[2*TW-1:TW];
  assign cos_o = rd_q[TW-1:0];

endmodule

`default_nettype wire

### rtl/rotated_rect_bounding_box_core.sv
// rotated rectangle bounding box, six stage pipeline
// throughput: one word per cycle unless m_axis_tready stalls the per-stage handshake
// the octant sine/cosine table read is stage three
// reset clears all valid bits only; no clearing pass
`default_nettype none

`include "rotated_rect_bounding_box_core_assert.svh"

module rotated_rect_bounding_box_core #(
  parameter int unsigned TRIG_FRAC_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // rect_x[23:0], rect_y[47:24], rect_w[70:48], rect_h[93:71], angle[109:94]
  input  wire logic [rrbb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // box_x[24:0], box_y[49:25], box_w[73:50], box_h[97:74]
  output logic      [rrbb_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned F   = TRIG_FRAC_BITS;
  localparam int unsigned TW  = F + 1;
  localparam int unsigned PW  = rrbb_pkg::LEN_W + TW;
  localparam int unsigned EW  = PW + 1;
  localparam int unsigned CW  = 26 + F;
  localparam int unsigned NW  = CW + 2;
  localparam int unsigned QW  = NW - F - 1;
  localparam int unsigned WW  = EW + 1;
  localparam int unsigned RW  = WW - F;

  // per-stage valid and enable
  logic [6:1] v_q;
  logic [6:1] en;

  assign en[6] = !v_q[6] || m_axis_tready;
  assign en[5] = !v_q[5] || en[6];
  assign en[4] = !v_q[4] || en[5];
  assign en[3] = !v_q[3] || en[4];
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign s_axis_tready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= s_axis_tvalid;
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      if (en[4]) v_q[4] <= v_q[3];
      if (en[5]) v_q[5] <= v_q[4];
      if (en[6]) v_q[6] <= v_q[5];
    end
  end

  // field unpack
  logic signed [15:0] in_ang;
  assign in_ang = signed'(s_axis_tdata[109:94]);

  // stage 1: angle modulo full turn
  logic signed [16:0] ang_ext, ang_p1;
  logic [14:0]        r1_d;
  always_comb begin
    ang_ext = 17'(in_ang);
    ang_p1  = ang_ext + signed'({2'b00, rrbb_pkg::FULL_TURN});
    if (in_ang < 0) begin
      if (ang_p1 < 0) r1_d = 15'(ang_p1 + signed'({2'b00, rrbb_pkg::FULL_TURN}));
      else            r1_d = ang_p1[14:0];
    end else if (ang_ext >= signed'({2'b00, rrbb_pkg::FULL_TURN})) begin
      r1_d = 15'(ang_ext - signed'({2'b00, rrbb_pkg::FULL_TURN}));
    end else begin
      r1_d = ang_ext[14:0];
    end
  end

  logic signed [23:0] x1_q, x2_q, x3_q, x4_q, x5_q;
  logic signed [23:0] y1_q, y2_q, y3_q, y4_q, y5_q;
  logic [22:0]        w1_q, w2_q, w3_q, w4_q, w5_q;
  logic [22:0]        h1_q, h2_q, h3_q, h4_q, h5_q;
  logic [5:1]         zero_q;
  logic [14:0]        r1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x1_q      <= signed'(s_axis_tdata[23:0]);
      y1_q      <= signed'(s_axis_tdata[47:24]);
      w1_q      <= s_axis_tdata[70:48];
      h1_q      <= s_axis_tdata[93:71];
      zero_q[1] <= (in_ang == 16'sd0);
      r1_q      <= r1_d;
    end
  end

  // stage 2: fold into one octant
  logic [13:0] fa;
  logic [12:0] fb;
  logic        swap2_d;
  logic [rrbb_pkg::ANG_IDX_W-1:0] b2_d, b2_q;
  logic        swap2_q, swap3_q;
  always_comb begin
    if (r1_q >= rrbb_pkg::HALF_TURN) fa = 14'(r1_q - rrbb_pkg::HALF_TURN);
    else                             fa = r1_q[13:0];
    if ({1'b0, fa} > {2'b00, rrbb_pkg::QUARTER_TURN}) fb = 13'(rrbb_pkg::HALF_TURN - {1'b0, fa});
    else                                              fb = fa[12:0];
    swap2_d = fb > {1'b0, rrbb_pkg::EIGHTH_TURN};
    if (swap2_d) b2_d = 12'(rrbb_pkg::QUARTER_TURN - fb);
    else         b2_d = fb[11:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      x2_q <= x1_q; y2_q <= y1_q; w2_q <= w1_q; h2_q <= h1_q;
      zero_q[2] <= zero_q[1];
      b2_q <= b2_d;
      swap2_q <= swap2_d;
    end
  end

  // stage 3: table read
  logic [TW-1:0] sin3, cos3;
  rrbb_trig_rom #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig_rom (
    .clk_i  (clk_i),
    .en_i   (en[3]),
    .addr_i (b2_q),
    .sin_o  (sin3),
    .cos_o  (cos3)
  );

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      x3_q <= x2_q; y3_q <= y2_q; w3_q <= w2_q; h3_q <= h2_q;
      zero_q[3] <= zero_q[2];
      swap3_q <= swap2_q;
    end
  end

  // stage 4: four products
  logic [TW-1:0] as4, ac4;
  logic [PW-1:0] pwc_q, phs_q, pws_q, phc_q;
  assign as4 = swap3_q ? cos3 : sin3;
  assign ac4 = swap3_q ? sin3 : cos3;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      x4_q <= x3_q; y4_q <= y3_q; w4_q <= w3_q; h4_q <= h3_q;
      zero_q[4] <= zero_q[3];
      pwc_q <= PW'(w3_q) * PW'(ac4);
      phs_q <= PW'(h3_q) * PW'(as4);
      pws_q <= PW'(w3_q) * PW'(as4);
      phc_q <= PW'(h3_q) * PW'(ac4);
    end
  end

  // stage 5: extents and scaled doubled centers
  logic [EW-1:0]        ew_q, eh_q;
  logic signed [CW-1:0] cxs_q, cys_q;
  logic signed [25:0]   cx2, cy2;
  assign cx2 = 26'(x4_q) + 26'(x4_q) + signed'({3'b000, w4_q});
  assign cy2 = 26'(y4_q) + 26'(y4_q) + signed'({3'b000, h4_q});

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      x5_q <= x4_q; y5_q <= y4_q; w5_q <= w4_q; h5_q <= h4_q;
      zero_q[5] <= zero_q[4];
      ew_q  <= EW'(pwc_q) + EW'(phs_q);
      eh_q  <= EW'(pws_q) + EW'(phc_q);
      cxs_q <= CW'(cx2) <<< F;
      cys_q <= CW'(cy2) <<< F;
    end
  end

  // stage 6: round, clamp, output register; a zero angle passes the input rectangle through
  localparam logic signed [NW-1:0] HALF_NUM = NW'(1) << F;
  localparam logic [WW-1:0]        HALF_LEN = WW'(1) << (F - 1);
  localparam logic signed [QW-1:0] POS_MAX  = QW'(24'hFF_FFFF);
  localparam logic signed [QW-1:0] POS_MIN  = -QW'(25'h100_0000);
  localparam logic [RW-1:0]        LEN_MAX  = RW'(24'hFF_FFFF);

  logic signed [NW-1:0] numx, numy;
  logic signed [QW-1:0] qx, qy;
  logic [WW-1:0]        sw, sh;
  logic [RW-1:0]        qw, qh;
  logic [rrbb_pkg::BOXP_W-1:0] bx, by;
  logic [rrbb_pkg::BOXL_W-1:0] bw, bh;

  always_comb begin
    numx = NW'(cxs_q) - signed'({2'b00, ew_q}) + HALF_NUM;
    numy = NW'(cys_q) - signed'({2'b00, eh_q}) + HALF_NUM;
    qx   = QW'(numx >>> (F + 1));
    qy   = QW'(numy >>> (F + 1));
    sw   = WW'(ew_q) + HALF_LEN;
    sh   = WW'(eh_q) + HALF_LEN;
    qw   = RW'(sw >> F);
    qh   = RW'(sh >> F);
    if (zero_q[5]) begin
      bx = rrbb_pkg::BOXP_W'(x5_q);
      by = rrbb_pkg::BOXP_W'(y5_q);
      bw = {1'b0, w5_q};
      bh = {1'b0, h5_q};
    end else begin
      if (qx > POS_MAX)      bx = POS_MAX[rrbb_pkg::BOXP_W-1:0];
      else if (qx < POS_MIN) bx = POS_MIN[rrbb_pkg::BOXP_W-1:0];
      else                   bx = qx[rrbb_pkg::BOXP_W-1:0];
      if (qy > POS_MAX)      by = POS_MAX[rrbb_pkg::BOXP_W-1:0];
      else if (qy < POS_MIN) by = POS_MIN[rrbb_pkg::BOXP_W-1:0];
      else                   by = qy[rrbb_pkg::BOXP_W-1:0];
      bw = (qw > LEN_MAX) ? LEN_MAX[rrbb_pkg::BOXL_W-1:0] : qw[rrbb_pkg::BOXL_W-1:0];
      bh = (qh > LEN_MAX) ? LEN_MAX[rrbb_pkg::BOXL_W-1:0] : qh[rrbb_pkg::BOXL_W-1:0];
    end
  end

  logic [rrbb_pkg::OUT_DATA_W-1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      out_q <= {6'b0, bh, bw, by, bx};
    end
  end

  assign m_axis_tvalid = v_q[6];
  assign m_axis_tdata  = out_q;

  // checks
  `RRBB_ASSERT_NOW(a_idx_in_octant, v_q[2], b2_q <= rrbb_pkg::EIGHTH_TURN)
  `RRBB_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  `RRBB_ASSERT_NEXT(a_zero_passes_width, v_q[5] && zero_q[5] && en[6],
                    m_axis_tdata[73:50] == {1'b0, $past(w5_q)})

endmodule

`default_nettype wire
